>>> sv/prr_pkg.sv
`default_nettype none
package prr_pkg;

  localparam int DATA_W           = 32;
  localparam int MODE_W           = 4;
  localparam int CFG_IDX_W        = 3;
  localparam int POS_W            = 5;
  localparam int FACTOR_BITS_DEF  = 8;
  localparam int POW2_MAX_EXP_DEF = 15;
  localparam int QUEUE_DEPTH      = 2;

  // Bit positions inside mode_flags.
  localparam int MODE_N_EXACT    = 0;
  localparam int MODE_N_ZERO_ONE = 1;
  localparam int MODE_P_POW2     = 2;
  localparam int MODE_M_DOUBLE   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_N_MASK,
    CFG_K_MASK,
    CFG_M_MASK,
    CFG_P_MASK,
    CFG_EN_MASK,
    CFG_MODE
  } cfg_reg_t;

  // Position of the lowest set bit; zero for an empty mask.
  function automatic logic [POS_W-1:0] low_bit(input logic [DATA_W-1:0] mask);
    logic [POS_W-1:0] pos;
    pos = '0;
    for (int i = DATA_W - 1; i >= 0; i--) begin
      if (mask[i]) pos = POS_W'(i);
    end
    return pos;
  endfunction

endpackage
`default_nettype wire

>>> sv/prr_item_if.sv
`default_nettype none
interface prr_item_if;
  logic                        valid;
  logic                        ready;
  logic [prr_pkg::DATA_W-1:0]  reg_value;
  logic [prr_pkg::DATA_W-1:0]  parent_rate;

  modport source (output valid, reg_value, parent_rate, input ready);
  modport sink (input valid, reg_value, parent_rate, output ready);
endinterface
`default_nettype wire

>>> sv/prr_result_if.sv
`default_nettype none
interface prr_result_if;
  logic                        valid;
  logic                        ready;
  logic [prr_pkg::DATA_W-1:0]  out_rate;
  logic                        rate_overflow;

  modport source (output valid, out_rate, rate_overflow, input ready);
  modport sink (input valid, out_rate, rate_overflow, output ready);
endinterface
`default_nettype wire

>>> sv/prr_front.sv
`default_nettype none
module prr_front #(
  parameter int FACTOR_BITS  = prr_pkg::FACTOR_BITS_DEF,
  parameter int POW2_MAX_EXP = prr_pkg::POW2_MAX_EXP_DEF,
  localparam int EXP_W       = $clog2(POW2_MAX_EXP + 1),
  localparam int ITEM_W      = prr_pkg::DATA_W + 4 * FACTOR_BITS + 5 + EXP_W
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [prr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [prr_pkg::DATA_W-1:0]      cfg_data,
  prr_item_if.sink                             item,
  output logic                                 push_valid,
  input  wire logic                            push_ready,
  output logic [ITEM_W-1:0]                    push_data
);

  localparam int FB = FACTOR_BITS;

  logic [prr_pkg::DATA_W-1:0] n_mask, k_mask, m_mask, p_mask, en_mask;
  logic [prr_pkg::POS_W-1:0]  n_pos, k_pos, m_pos, p_pos;
  logic [prr_pkg::MODE_W-1:0] mode;

  // Mask shift amounts are found when the mask is written, not per request.
  always_ff @(posedge clk) begin
    if (rst) begin
      n_mask  <= '0;
      k_mask  <= '0;
      m_mask  <= '0;
      p_mask  <= '0;
      en_mask <= '0;
      mode    <= '0;
      n_pos   <= '0;
      k_pos   <= '0;
      m_pos   <= '0;
      p_pos   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        prr_pkg::CFG_N_MASK: begin
          n_mask <= cfg_data;
          n_pos  <= prr_pkg::low_bit(cfg_data);
        end
        prr_pkg::CFG_K_MASK: begin
          k_mask <= cfg_data;
          k_pos  <= prr_pkg::low_bit(cfg_data);
        end
        prr_pkg::CFG_M_MASK: begin
          m_mask <= cfg_data;
          m_pos  <= prr_pkg::low_bit(cfg_data);
        end
        prr_pkg::CFG_P_MASK: begin
          p_mask <= cfg_data;
          p_pos  <= prr_pkg::low_bit(cfg_data);
        end
        prr_pkg::CFG_EN_MASK: en_mask <= cfg_data;
        prr_pkg::CFG_MODE:    mode    <= cfg_data[prr_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [prr_pkg::DATA_W-1:0] n_sh, k_sh, m_sh, p_sh;
  logic [FB-1:0]              n_raw, k_raw, m_raw, p_raw;
  logic [FB:0]                n_val, k_val, p_fac;
  logic [FB+1:0]              m_val;
  logic [EXP_W-1:0]           p_exp;
  logic [prr_pkg::DATA_W-1:0] parent;

  always_comb begin
    n_sh  = (item.reg_value & n_mask) >> n_pos;
    k_sh  = (item.reg_value & k_mask) >> k_pos;
    m_sh  = (item.reg_value & m_mask) >> m_pos;
    p_sh  = (item.reg_value & p_mask) >> p_pos;
    n_raw = n_sh[FB-1:0];
    k_raw = k_sh[FB-1:0];
    m_raw = m_sh[FB-1:0];
    p_raw = p_sh[FB-1:0];

    if (mode[prr_pkg::MODE_N_EXACT]) begin
      n_val = {1'b0, n_raw};
      if (mode[prr_pkg::MODE_N_ZERO_ONE] && n_raw == '0) n_val = (FB+1)'(1);
    end else begin
      n_val = {1'b0, n_raw} + (FB+1)'(1);
    end

    k_val = {1'b0, k_raw} + (FB+1)'(1);
    m_val = {2'b00, m_raw} + (FB+2)'(1);
    if (mode[prr_pkg::MODE_M_DOUBLE]) m_val = {m_val[FB:0], 1'b0};

    // A power-of-two divider becomes a right shift of the numerator.
    if (mode[prr_pkg::MODE_P_POW2]) begin
      p_fac = (FB+1)'(1);
      if (32'(p_raw) > 32'(POW2_MAX_EXP)) p_exp = EXP_W'(POW2_MAX_EXP);
      else p_exp = EXP_W'(p_raw);
    end else begin
      p_fac = {1'b0, p_raw} + (FB+1)'(1);
      p_exp = '0;
    end

    // A zero parent drives the whole product, and so the rate, to zero.
    parent = item.parent_rate;
    if (en_mask != '0 && (item.reg_value & en_mask) == '0) parent = '0;
  end

  assign push_valid = item.valid;
  assign item.ready = push_ready;
  assign push_data  = {parent, n_val, k_val, m_val, p_fac, p_exp};

endmodule
`default_nettype wire

>>> sv/prr_queue.sv
`default_nettype none
module prr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = prr_pkg::QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output logic [WIDTH-1:0]      rd_data
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push, pop;

  assign wr_ready = count != CNT_W'(DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop) count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_data;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("queue count above depth");
  a_full_after_fill: assert property (@(posedge clk) disable iff (rst)
    count == CNT_W'(DEPTH - 1) && push && !pop |=> !wr_ready)
    else $error("queue did not report full");

endmodule
`default_nettype wire

>>> sv/prr_back.sv
`default_nettype none
module prr_back #(
  parameter int FACTOR_BITS  = prr_pkg::FACTOR_BITS_DEF,
  parameter int POW2_MAX_EXP = prr_pkg::POW2_MAX_EXP_DEF,
  localparam int EXP_W       = $clog2(POW2_MAX_EXP + 1),
  localparam int ITEM_W      = prr_pkg::DATA_W + 4 * FACTOR_BITS + 5 + EXP_W
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              pop_valid,
  output logic                   pop_ready,
  input  wire logic [ITEM_W-1:0] pop_data,
  prr_result_if.source           result
);

  localparam int FB    = FACTOR_BITS;
  localparam int DW    = prr_pkg::DATA_W;
  localparam int A_W   = DW + FB + 1;
  localparam int NUM_W = DW + 2 * FB + 2;
  localparam int DEN_W = 2 * FB + 3;

  logic [DW-1:0]    in_parent;
  logic [FB:0]      in_n, in_k, in_pf;
  logic [FB+1:0]    in_m;
  logic [EXP_W-1:0] in_e;

  assign {in_parent, in_n, in_k, in_m, in_pf, in_e} = pop_data;

  // The whole pipeline moves together unless the result waits on the sink.
  logic adv;
  logic vo;
  assign adv       = !vo || result.ready;
  assign pop_ready = adv;

  logic             v1, v2;
  logic [A_W-1:0]   s1_a;
  logic [FB:0]      s1_k;
  logic [DEN_W-1:0] s1_d, s2_d;
  logic [EXP_W-1:0] s1_e, s2_e;
  logic [NUM_W-1:0] s2_num;

  logic             dv_vld [NUM_W+1];
  logic [DEN_W-1:0] dv_rem [NUM_W+1];
  logic [NUM_W-1:0] dv_nq  [NUM_W+1];
  logic [DEN_W-1:0] dv_den [NUM_W+1];

  logic [DW-1:0]    o_rate;
  logic             o_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      dv_vld[0] <= 1'b0;
    end else if (adv) begin
      v1        <= pop_valid;
      v2        <= v1;
      dv_vld[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_a      <= A_W'(in_parent) * A_W'(in_n);
      s1_d      <= DEN_W'(in_m) * DEN_W'(in_pf);
      s1_k      <= in_k;
      s1_e      <= in_e;
      s2_num    <= NUM_W'(s1_a) * NUM_W'(s1_k);
      s2_d      <= s1_d;
      s2_e      <= s1_e;
      dv_rem[0] <= '0;
      dv_nq[0]  <= s2_num >> s2_e;
      dv_den[0] <= s2_d;
    end
  end

  // Restoring division, one quotient bit per stage; quotient bits shift in
  // at the bottom as the dividend bits leave at the top.
  for (genvar i = 1; i <= NUM_W; i++) begin : g_div
    logic [DEN_W:0]   trial;
    logic             take;
    logic [DEN_W-1:0] rem_next;

    always_comb begin
      trial    = {dv_rem[i-1], dv_nq[i-1][NUM_W-1]};
      take     = trial >= {1'b0, dv_den[i-1]};
      rem_next = take ? DEN_W'(trial - {1'b0, dv_den[i-1]}) : trial[DEN_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) dv_vld[i] <= 1'b0;
      else if (adv) dv_vld[i] <= dv_vld[i-1];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[i] <= rem_next;
        dv_nq[i]  <= {dv_nq[i-1][NUM_W-2:0], take};
        dv_den[i] <= dv_den[i-1];
      end
    end
  end

  logic ovf_next;
  assign ovf_next = dv_nq[NUM_W][NUM_W-1:DW] != '0;

  always_ff @(posedge clk) begin
    if (rst) vo <= 1'b0;
    else if (adv) vo <= dv_vld[NUM_W];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_ovf  <= ovf_next;
      o_rate <= ovf_next ? '1 : dv_nq[NUM_W][DW-1:0];
    end
  end

  assign result.valid         = vo;
  assign result.out_rate      = o_rate;
  assign result.rate_overflow = o_ovf;

  a_sat: assert property (@(posedge clk) disable iff (rst)
    vo && o_ovf |-> o_rate == '1) else $error("overflow without saturation");
  a_rem: assert property (@(posedge clk) disable iff (rst)
    dv_vld[NUM_W] |-> dv_rem[NUM_W] < dv_den[NUM_W])
    else $error("division remainder not below divisor");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    v1 && adv |=> v2) else $error("request lost between multiplier stages");

endmodule
`default_nettype wire

>>> sv/pll_nkmp_rate_readback.sv
// PLL output rate readback: out_rate = parent_rate * N * K / (M * P).
//
// Requests arrive on the item channel (reg_value, parent_rate) and results
// leave on the result channel (out_rate, rate_overflow), both valid/ready.
// The user must write the field masks, enable mask and mode flags through the
// cfg_we / cfg_index / cfg_data port only while no request is in flight (not enforced).
//
// One request is taken every cycle while the result sink keeps up. A request
// is classified in the front end and queued; the back end runs it through
// two multiplier stages, a shift stage, a restoring divider with one stage
// per numerator bit and an output register.
// When the result sink stalls, the back pipeline holds, the two-entry
// queue fills, and then item.ready drops.
// Synchronous reset clears all configuration to zero and empties the
// queue and pipeline.
`default_nettype none
module pll_nkmp_rate_readback #(
  parameter int FACTOR_BITS  = prr_pkg::FACTOR_BITS_DEF,
  parameter int POW2_MAX_EXP = prr_pkg::POW2_MAX_EXP_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [prr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [prr_pkg::DATA_W-1:0]    cfg_data,
  prr_item_if.sink                           item,
  prr_result_if.source                       result
);

  localparam int EXP_W  = $clog2(POW2_MAX_EXP + 1);
  localparam int ITEM_W = prr_pkg::DATA_W + 4 * FACTOR_BITS + 5 + EXP_W;

  logic              push_valid, push_ready;
  logic [ITEM_W-1:0] push_data;
  logic              pop_valid, pop_ready;
  logic [ITEM_W-1:0] pop_data;

  prr_front #(
    .FACTOR_BITS  (FACTOR_BITS),
    .POW2_MAX_EXP (POW2_MAX_EXP)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item       (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  prr_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (prr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_data),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (pop_data)
  );

  prr_back #(
    .FACTOR_BITS  (FACTOR_BITS),
    .POW2_MAX_EXP (POW2_MAX_EXP)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .result    (result)
  );

endmodule
`default_nettype wire
